FILE: design/dfm_pkg.sv
package dfm_pkg;

  localparam int NUM_CHECKS = 7;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int FAULT_W    = 19;

  localparam logic [3:0] STARTUP_STATE_DEF = 4'd2;
  localparam logic [3:0] MAINT_STATE_DEF   = 4'd5;
  localparam logic [4:0] SUB_STARTUP       = 5'd3;
  localparam logic [4:0] SUB_MAINT         = 5'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LP_OV     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LP_UV     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUS_OC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_OT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_OT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OC  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OVSPD     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST   = 3'd7;

  // persistence check lanes
  localparam int CHK_LPOV    = 0;
  localparam int CHK_LPUV    = 1;
  localparam int CHK_BUSOC   = 2;
  localparam int CHK_STAGEOT = 3;
  localparam int CHK_MOTOROT = 4;
  localparam int CHK_PHASEOC = 5;
  localparam int CHK_OVSPD   = 6;

  // fault word layout
  localparam int FB_CHECK_LO = 8;
  localparam int FB_HW       = 15;
  localparam int FB_STARTUP  = 16;
  localparam int FB_SOFT     = 17;
  localparam int FB_CALIB    = 18;

  // side flag bits
  localparam int SF_HW      = 0;
  localparam int SF_SOFT    = 1;
  localparam int SF_CALIB   = 2;
  localparam int SF_STARTOK = 3;

  typedef struct packed {
    logic        [15:0] lp_volt;
    logic signed [15:0] bus_current;
    logic signed [15:0] stage_temp;
    logic signed [15:0] motor_temp;
    logic signed [15:0] q_current;
    logic signed [15:0] d_current;
    logic signed [31:0] speed_fdb;
    logic        [7:0]  ext_fault;
    logic        [3:0]  main_state;
    logic        [4:0]  sub_state;
    logic        [3:0]  side_flags;
  } in_item_t;

  typedef struct packed {
    logic [FAULT_W-1:0] fault_word;
    logic               clear_ext;
    logic               clear_calib;
  } out_item_t;

  typedef struct packed {
    logic        [15:0]      lp_overvolt_limit;
    logic        [15:0]      lp_undervolt_limit;
    logic signed [15:0]      bus_overcurrent_limit;
    logic signed [15:0]      stage_overtemp_limit;
    logic signed [15:0]      motor_overtemp_limit;
    logic        [15:0]      phase_overcurrent_limit;
    logic        [30:0]      overspeed_limit;
    logic        [CNT_W-1:0] persist_count;
  } cfg_t;

endpackage

FILE: design/dfm_cfg.sv
module dfm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output dfm_pkg::cfg_t                    cfg
);

  dfm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lp_overvolt_limit       <= 16'hFFFF;
      cfg_r.lp_undervolt_limit      <= 16'h0000;
      cfg_r.bus_overcurrent_limit   <= 16'sh7FFF;
      cfg_r.stage_overtemp_limit    <= 16'sh7FFF;
      cfg_r.motor_overtemp_limit    <= 16'sh7FFF;
      cfg_r.phase_overcurrent_limit <= 16'h8000;
      cfg_r.overspeed_limit         <= 31'h7FFF_FFFF;
      cfg_r.persist_count           <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfm_pkg::REG_LP_OV:    cfg_r.lp_overvolt_limit       <= cfg_wdata[15:0];
        dfm_pkg::REG_LP_UV:    cfg_r.lp_undervolt_limit      <= cfg_wdata[15:0];
        dfm_pkg::REG_BUS_OC:   cfg_r.bus_overcurrent_limit   <= $signed(cfg_wdata[15:0]);
        dfm_pkg::REG_STAGE_OT: cfg_r.stage_overtemp_limit    <= $signed(cfg_wdata[15:0]);
        dfm_pkg::REG_MOTOR_OT: cfg_r.motor_overtemp_limit    <= $signed(cfg_wdata[15:0]);
        dfm_pkg::REG_PHASE_OC: cfg_r.phase_overcurrent_limit <= cfg_wdata[15:0];
        dfm_pkg::REG_OVSPD:    cfg_r.overspeed_limit         <= cfg_wdata[30:0];
        dfm_pkg::REG_PERSIST:  cfg_r.persist_count  <= cfg_wdata[dfm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/dfm_persist.sv
module dfm_persist (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [dfm_pkg::NUM_CHECKS-1:0]   cond,
  input  logic [dfm_pkg::CNT_W-1:0]        persist_count,
  output logic [dfm_pkg::NUM_CHECKS-1:0]   fire
);

  logic [dfm_pkg::CNT_W-1:0] cnt_r   [dfm_pkg::NUM_CHECKS];
  logic [dfm_pkg::CNT_W-1:0] cnt_nxt [dfm_pkg::NUM_CHECKS];

  // a counter left above a lowered limit holds and still counts as at the limit
  always_comb begin
    for (int i = 0; i < dfm_pkg::NUM_CHECKS; i++) begin
      fire[i] = cond[i] && (cnt_r[i] >= persist_count);
      if (!cond[i]) begin
        cnt_nxt[i] = '0;
      end else if (cnt_r[i] < persist_count) begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end else begin
        cnt_nxt[i] = cnt_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dfm_pkg::NUM_CHECKS; i++) cnt_r[i] <= '0;
    end else if (en) begin
      for (int i = 0; i < dfm_pkg::NUM_CHECKS; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

endmodule

FILE: design/debounced_fault_monitor.sv
// The result passes through the input register, then the result register;
// an output stall holds a transaction in the input register.
// Throughput: one transaction per cycle while the output is not stalled; the seven
// comparators and persistence counters all update in the single evaluate stage.
// Reset (rst_n low, synchronous): pipeline empty, persistence counters zero,
// thresholds at their default values.
module debounced_fault_monitor #(
  parameter logic [3:0] STARTUP_STATE = dfm_pkg::STARTUP_STATE_DEF,
  parameter logic [3:0] MAINT_STATE   = dfm_pkg::MAINT_STATE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dfm_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dfm_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [dfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  dfm_pkg::cfg_t      cfg;
  dfm_pkg::in_item_t  s1_data_r;
  logic               s1_valid_r;
  dfm_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_valid_r;
  logic               s1_adv;

  logic [dfm_pkg::NUM_CHECKS-1:0] cond, fire;
  logic [15:0] aq, ad, aph;
  logic [31:0] aspd;
  logic        startup_fail;

  dfm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // 16-bit magnitudes wrap -32768 to 0x8000, which is exact as unsigned
  always_comb begin
    aq   = s1_data_r.q_current[15] ? (~s1_data_r.q_current + 16'd1)
                                   : s1_data_r.q_current;
    ad   = s1_data_r.d_current[15] ? (~s1_data_r.d_current + 16'd1)
                                   : s1_data_r.d_current;
    aph  = (aq > ad) ? aq : ad;
    aspd = s1_data_r.speed_fdb[31] ? (~s1_data_r.speed_fdb + 32'd1)
                                   : s1_data_r.speed_fdb;

    cond[dfm_pkg::CHK_LPOV]    = s1_data_r.lp_volt > cfg.lp_overvolt_limit;
    cond[dfm_pkg::CHK_LPUV]    = s1_data_r.lp_volt < cfg.lp_undervolt_limit;
    cond[dfm_pkg::CHK_BUSOC]   = s1_data_r.bus_current > cfg.bus_overcurrent_limit;
    cond[dfm_pkg::CHK_STAGEOT] = s1_data_r.stage_temp > cfg.stage_overtemp_limit;
    cond[dfm_pkg::CHK_MOTOROT] = s1_data_r.motor_temp > cfg.motor_overtemp_limit;
    cond[dfm_pkg::CHK_PHASEOC] = aph > cfg.phase_overcurrent_limit;
    cond[dfm_pkg::CHK_OVSPD]   = aspd > {1'b0, cfg.overspeed_limit};
  end

  dfm_persist u_persist (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (s1_adv),
    .cond          (cond),
    .persist_count (cfg.persist_count),
    .fire          (fire)
  );

  always_comb begin
    startup_fail = (((s1_data_r.main_state == STARTUP_STATE) &&
                     (s1_data_r.sub_state == dfm_pkg::SUB_STARTUP)) ||
                    ((s1_data_r.main_state == MAINT_STATE) &&
                     (s1_data_r.sub_state == dfm_pkg::SUB_MAINT))) &&
                   !s1_data_r.side_flags[dfm_pkg::SF_STARTOK];

    out_data_nxt.fault_word[7:0] = s1_data_r.ext_fault;
    out_data_nxt.fault_word[dfm_pkg::FB_CHECK_LO +: dfm_pkg::NUM_CHECKS] = fire;
    out_data_nxt.fault_word[dfm_pkg::FB_HW]      = s1_data_r.side_flags[dfm_pkg::SF_HW];
    out_data_nxt.fault_word[dfm_pkg::FB_STARTUP] = startup_fail;
    out_data_nxt.fault_word[dfm_pkg::FB_SOFT]    = s1_data_r.side_flags[dfm_pkg::SF_SOFT];
    out_data_nxt.fault_word[dfm_pkg::FB_CALIB]   = s1_data_r.side_flags[dfm_pkg::SF_CALIB];
    out_data_nxt.clear_ext   = |s1_data_r.ext_fault;
    out_data_nxt.clear_calib = s1_data_r.side_flags[dfm_pkg::SF_CALIB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // empty input stage always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("in_ready low with empty input stage");

  // a stalled output must not drop the held input-stage transaction
  a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> s1_valid_r)
    else $error("input stage transaction lost during output stall");

  // result request flag tracks the copied external byte
  a_clear_ext_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.clear_ext == (out_data_r.fault_word[7:0] != 8'd0)))
    else $error("clear_ext inconsistent with external fault byte");

endmodule

FILE: bench/dfm_checker.sv
`timescale 1ns / 100ps

module dfm_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  dfm_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  dfm_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [dfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fault_mismatches,
  output int                             words_pending
);
  import dfm_pkg::*;

  logic        [15:0] lim_lp_ov;
  logic        [15:0] lim_lp_uv;
  logic signed [15:0] lim_bus;
  logic signed [15:0] lim_stage;
  logic signed [15:0] lim_motor;
  logic        [15:0] lim_phase;
  logic        [30:0] lim_speed;
  logic        [7:0]  persist_lim;
  logic        [7:0]  trip_cnt [NUM_CHECKS];

  out_item_t fault_words_due [$];
  int        mismatch_cnt = 0;

  // counter saturates at the persistence limit; a count already above a
  // freshly lowered limit is left alone and still counts as tripped
  function automatic bit debounce(input int lane, input bit cond);
    if (!cond) begin
      trip_cnt[lane] = '0;
      return 1'b0;
    end
    if (trip_cnt[lane] < persist_lim) begin
      trip_cnt[lane] = trip_cnt[lane] + 8'd1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t eval_fault_word(input in_item_t s);
    out_item_t   r;
    logic [16:0] mag_q;
    logic [16:0] mag_d;
    logic [16:0] mag_ph;
    logic [31:0] mag_spd;
    mag_q   = s.q_current[15] ? (17'd0 - {1'b1, s.q_current}) : {1'b0, s.q_current};
    mag_d   = s.d_current[15] ? (17'd0 - {1'b1, s.d_current}) : {1'b0, s.d_current};
    mag_ph  = (mag_q > mag_d) ? mag_q : mag_d;
    mag_spd = s.speed_fdb[31] ? (32'd0 - s.speed_fdb) : s.speed_fdb;

    r = '0;
    r.fault_word[7:0] = s.ext_fault;
    r.fault_word[FB_CHECK_LO + CHK_LPOV] = debounce(CHK_LPOV, s.lp_volt > lim_lp_ov);
    r.fault_word[FB_CHECK_LO + CHK_LPUV] = debounce(CHK_LPUV, s.lp_volt < lim_lp_uv);
    r.fault_word[FB_CHECK_LO + CHK_BUSOC] =
      debounce(CHK_BUSOC, $signed(s.bus_current) > $signed(lim_bus));
    r.fault_word[FB_CHECK_LO + CHK_STAGEOT] =
      debounce(CHK_STAGEOT, $signed(s.stage_temp) > $signed(lim_stage));
    r.fault_word[FB_CHECK_LO + CHK_MOTOROT] =
      debounce(CHK_MOTOROT, $signed(s.motor_temp) > $signed(lim_motor));
    r.fault_word[FB_CHECK_LO + CHK_PHASEOC] =
      debounce(CHK_PHASEOC, mag_ph > {1'b0, lim_phase});
    r.fault_word[FB_CHECK_LO + CHK_OVSPD] = debounce(CHK_OVSPD, mag_spd > {1'b0, lim_speed});
    r.fault_word[FB_HW] = s.side_flags[SF_HW];
    r.fault_word[FB_STARTUP] = !s.side_flags[SF_STARTOK] &&
      ((s.main_state == STARTUP_STATE_DEF && s.sub_state == SUB_STARTUP) ||
       (s.main_state == MAINT_STATE_DEF && s.sub_state == SUB_MAINT));
    r.fault_word[FB_SOFT]  = s.side_flags[SF_SOFT];
    r.fault_word[FB_CALIB] = s.side_flags[SF_CALIB];
    r.clear_ext   = |s.ext_fault;
    r.clear_calib = s.side_flags[SF_CALIB];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      lim_lp_ov   = 16'hFFFF;
      lim_lp_uv   = 16'h0000;
      lim_bus     = 16'sh7FFF;
      lim_stage   = 16'sh7FFF;
      lim_motor   = 16'sh7FFF;
      lim_phase   = 16'h8000;
      lim_speed   = 31'h7FFF_FFFF;
      persist_lim = 8'd3;
      for (int k = 0; k < NUM_CHECKS; k++) trip_cnt[k] = '0;
      fault_words_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LP_OV:    lim_lp_ov   = cfg_wdata[15:0];
          REG_LP_UV:    lim_lp_uv   = cfg_wdata[15:0];
          REG_BUS_OC:   lim_bus     = cfg_wdata[15:0];
          REG_STAGE_OT: lim_stage   = cfg_wdata[15:0];
          REG_MOTOR_OT: lim_motor   = cfg_wdata[15:0];
          REG_PHASE_OC: lim_phase   = cfg_wdata[15:0];
          REG_OVSPD:    lim_speed   = cfg_wdata[30:0];
          REG_PERSIST:  persist_lim = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // retire before predicting so a stray result never matches a new transaction
      if (out_valid && out_ready) begin
        if (fault_words_due.size() == 0) begin
          $display("%0t: unexpected fault report %h, expected none", $time, out_data);
          mismatch_cnt++;
        end else begin
          want = fault_words_due.pop_front();
          if (out_data.fault_word !== want.fault_word) begin
            $display("%0t: fault_word expected %h actual %h", $time,
                     want.fault_word, out_data.fault_word);
            mismatch_cnt++;
          end
          if (out_data.clear_ext !== want.clear_ext) begin
            $display("%0t: clear_ext expected %b actual %b", $time,
                     want.clear_ext, out_data.clear_ext);
            mismatch_cnt++;
          end
          if (out_data.clear_calib !== want.clear_calib) begin
            $display("%0t: clear_calib expected %b actual %b", $time,
                     want.clear_calib, out_data.clear_calib);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready) fault_words_due.push_back(eval_fault_word(in_data));
    end
    fault_mismatches <= mismatch_cnt;
    words_pending    <= fault_words_due.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import dfm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int   fault_mismatches;
  int   words_pending;
  int   cycles     = 0;
  int   items_sent = 0;
  bit   idle_on    = 1'b1;
  int   hold_req   = 0;
  bit   hot [NUM_CHECKS];
  cfg_t cfg_now    = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  debounced_fault_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dfm_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fault_mismatches (fault_mismatches),
    .words_pending    (words_pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("debounced_fault_monitor: mismatch");
      $finish;
    end
  end

  task automatic send_item(input in_item_t s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding fault word, plus pipeline slack
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // upper bits of the narrow registers carry junk that the block must drop
  task automatic load_config(input cfg_t c);
    logic [30:0] junk;
    junk = 31'($urandom);
    write_reg(REG_LP_OV,    {junk[30:16], c.lp_overvolt_limit});
    write_reg(REG_LP_UV,    {junk[30:16], c.lp_undervolt_limit});
    write_reg(REG_BUS_OC,   {junk[30:16], c.bus_overcurrent_limit});
    write_reg(REG_STAGE_OT, {junk[30:16], c.stage_overtemp_limit});
    write_reg(REG_MOTOR_OT, {junk[30:16], c.motor_overtemp_limit});
    write_reg(REG_PHASE_OC, {junk[30:16], c.phase_overcurrent_limit});
    write_reg(REG_OVSPD,    c.overspeed_limit);
    write_reg(REG_PERSIST,  {junk[30:8], c.persist_count});
    cfg_we  <= 1'b0;
    cfg_now = c;
  endtask

  function automatic longint pick_limit(input longint lo, input longint hi);
    int unsigned span;
    span = 32'(hi - lo);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return lo + $urandom_range(0, span);
    endcase
  endfunction

  function automatic cfg_t make_config();
    cfg_t c;
    c.lp_overvolt_limit       = 16'(pick_limit(0, 65535));
    c.lp_undervolt_limit      = 16'(pick_limit(0, 65535));
    c.bus_overcurrent_limit   = 16'(pick_limit(-32768, 32767));
    c.stage_overtemp_limit    = 16'(pick_limit(-32768, 32767));
    c.motor_overtemp_limit    = 16'(pick_limit(-32768, 32767));
    c.phase_overcurrent_limit = 16'(pick_limit(0, 32768));
    c.overspeed_limit         = 31'(pick_limit(0, 2147483647));
    case ($urandom_range(0, 7))
      0:       c.persist_count = 8'd0;
      1:       c.persist_count = 8'd255;
      2:       c.persist_count = 8'($urandom_range(8, 40));
      default: c.persist_count = 8'($urandom_range(1, 6));
    endcase
    return c;
  endfunction

  // a value over the threshold when the lane is hot and the threshold is below top_v, else the threshold itself
  function automatic longint above(input longint lim, input longint top_v, input bit hot_lane);
    int unsigned span;
    if (!hot_lane || lim >= top_v) return lim;
    if ($urandom_range(0, 3) == 0) return lim + 1;
    span = 32'(top_v - lim - 1);
    return lim + 1 + $urandom_range(0, span);
  endfunction

  // each check lane flips between runs of true and mostly random readings,
  // so the persistence counters climb to their limits and get cleared
  function automatic in_item_t make_snapshot(input bit shaped);
    in_item_t     s;
    longint       m;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    s = raw[$bits(in_item_t)-1:0];
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1)) {s.main_state, s.sub_state} = {STARTUP_STATE_DEF, SUB_STARTUP};
      else {s.main_state, s.sub_state} = {MAINT_STATE_DEF, SUB_MAINT};
    end
    if (!shaped) return s;
    for (int k = 0; k < NUM_CHECKS; k++) if ($urandom_range(0, 15) == 0) hot[k] = !hot[k];

    if (hot[CHK_LPOV] || $urandom_range(0, 3) == 0)
      s.lp_volt = 16'(above(cfg_now.lp_overvolt_limit, 65535, hot[CHK_LPOV]));
    else if (hot[CHK_LPUV] && cfg_now.lp_undervolt_limit != 0)
      s.lp_volt = 16'($urandom_range(0, cfg_now.lp_undervolt_limit - 1));
    else if ($urandom_range(0, 3) == 0)
      s.lp_volt = cfg_now.lp_undervolt_limit;

    if (hot[CHK_BUSOC] || $urandom_range(0, 3) == 0)
      s.bus_current = 16'(above($signed(cfg_now.bus_overcurrent_limit), 32767,
                                hot[CHK_BUSOC]));
    if (hot[CHK_STAGEOT] || $urandom_range(0, 3) == 0)
      s.stage_temp = 16'(above($signed(cfg_now.stage_overtemp_limit), 32767,
                               hot[CHK_STAGEOT]));
    if (hot[CHK_MOTOROT] || $urandom_range(0, 3) == 0)
      s.motor_temp = 16'(above($signed(cfg_now.motor_overtemp_limit), 32767,
                               hot[CHK_MOTOROT]));

    if (hot[CHK_PHASEOC] || $urandom_range(0, 3) == 0) begin
      m = above(cfg_now.phase_overcurrent_limit, 32768, hot[CHK_PHASEOC]);
      if (m == 32768 || $urandom_range(0, 1)) m = -m;
      if ($urandom_range(0, 1)) s.q_current = 16'(m);
      else s.d_current = 16'(m);
    end

    if (hot[CHK_OVSPD] || $urandom_range(0, 3) == 0) begin
      m = above(cfg_now.overspeed_limit, 64'd2147483648, hot[CHK_OVSPD]);
      if (m == 64'd2147483648 || $urandom_range(0, 1)) m = -m;
      s.speed_fdb = 32'(m);
    end
    return s;
  endfunction

  // result side: ready stretches, short stalls, and one long hold-off on request
  initial begin : result_sink
    int n;
    int holds_seen;
    holds_seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req != holds_seen) begin
        holds_seen = hold_req;
        out_ready <= 1'b0;
        n = 120;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 14);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin : stimulus
    in_item_t    s;
    cfg_t        c;
    logic [30:0] junk;
    int          phase_no;
    int          phase_end;
    for (int k = 0; k < NUM_CHECKS; k++) hot[k] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default thresholds
    s = '0;
    send_item(s);
    s = '1;
    send_item(s);
    s = '0;
    s.lp_volt     = 16'hFFFF;
    s.bus_current = 16'sh7FFF;
    s.stage_temp  = 16'sh7FFF;
    s.motor_temp  = 16'sh7FFF;
    s.q_current   = 16'sh7FFF;
    s.d_current   = 16'sh7FFF;
    s.speed_fdb   = 32'sh7FFF_FFFF;
    s.ext_fault   = 8'h01;
    s.main_state  = STARTUP_STATE_DEF;
    s.sub_state   = SUB_STARTUP;
    send_item(s);
    // most negative readings: magnitude of min speed exceeds the default
    // overspeed limit, so the fourth transaction in a row trips it
    for (int k = 0; k < 4; k++) begin
      s = '0;
      s.bus_current = 16'sh8000;
      s.stage_temp  = 16'sh8000;
      s.motor_temp  = 16'sh8000;
      s.q_current   = 16'sh8000;
      s.d_current   = 16'sh8000;
      s.speed_fdb   = 32'sh8000_0000;
      s.ext_fault   = 8'h80;
      s.side_flags  = 4'b1000 >> k;
      if (k[0]) {s.main_state, s.sub_state} = {STARTUP_STATE_DEF, SUB_STARTUP};
      else {s.main_state, s.sub_state} = {MAINT_STATE_DEF, SUB_MAINT};
      send_item(s);
    end
    s = '0;
    s.main_state = STARTUP_STATE_DEF;
    s.sub_state  = SUB_MAINT;
    send_item(s);
    settle();

    // thresholds at the opposite extremes: everything mid-range is a fault
    c.lp_overvolt_limit       = 16'h0000;
    c.lp_undervolt_limit      = 16'hFFFF;
    c.bus_overcurrent_limit   = 16'sh8000;
    c.stage_overtemp_limit    = 16'sh8000;
    c.motor_overtemp_limit    = 16'sh8000;
    c.phase_overcurrent_limit = 16'h0000;
    c.overspeed_limit         = '0;
    c.persist_count           = 8'd5;
    load_config(c);
    s = '0;
    s.lp_volt   = 16'd1000;
    s.q_current = 16'sd100;
    s.d_current = -16'sd100;
    s.speed_fdb = 32'sd5;
    repeat (4) send_item(s);
    settle();
    // drop the limit below the running counts: next true transaction trips at once
    junk = 31'($urandom);
    write_reg(REG_PERSIST, {junk[30:8], 8'd1});
    cfg_we <= 1'b0;
    cfg_now.persist_count = 8'd1;
    repeat (2) send_item(s);
    s = '0;
    s.bus_current = 16'sh8000;
    s.stage_temp  = 16'sh8000;
    s.motor_temp  = 16'sh8000;
    send_item(s);
    s.lp_volt     = 16'd1000;
    s.bus_current = 16'sd0;
    s.speed_fdb   = 32'sd5;
    send_item(s);

    // random phases, each under a fresh set of thresholds
    phase_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      load_config(make_config());
      phase_no++;
      if (phase_no == 2 || phase_no == 6) hold_req++;
      phase_end = items_sent + $urandom_range(40, 200);
      while (items_sent < phase_end && items_sent < RANDOM_ITEMS) begin
        if (items_sent > RANDOM_ITEMS - 300) idle_on = 1'b0;
        send_item(make_snapshot($urandom_range(0, 9) != 0));
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fault_mismatches == 0 && words_pending == 0) begin
      $display("debounced_fault_monitor: match");
    end else begin
      $display("debounced_fault_monitor: mismatch");
    end
    $finish;
  end

endmodule
